@@ src/tlt_pkg.sv @@
// Shared types and constants for the triangle LFO tremolo block.
// Used by tlt_ctrl, tlt_dpath and triangle_lfo_tremolo; no dependencies.
package tlt_pkg;

    localparam int REG_W     = 15;            // rate_limit and depth width
    localparam int PHASE_W   = 16;            // triangle counter width
    localparam int PROD_W    = PHASE_W + REG_W; // phase * depth
    localparam int DIV_STEPS = PROD_W;        // one quotient bit per step
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int OUT_W     = 32;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    // Operation codes of the input channel
    localparam logic [1:0] OP_SAMPLE  = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;

    // Register indexes (paddr[2])
    localparam logic REG_RATE  = 1'b0;
    localparam logic REG_DEPTH = 1'b1;

    localparam logic [REG_W-1:0] RATE_RESET  = REG_W'(1);
    localparam logic [REG_W-1:0] DEPTH_RESET = '0;

    localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PROD = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_GAIN = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    typedef struct packed {
        logic accept;     // latch input payload
        logic tick;       // advance triangle counter
        logic restart;    // phase to zero, rising
        logic load_prod;  // phase * depth into divider
        logic div_step;   // one restoring divide step
        logic load_gain;  // gain * sample
        logic load_out;   // saturate into output register
    } t_cmd;

    typedef struct packed {
        logic out_free;   // output register can take a result this cycle
        logic falling;    // current sweep direction
    } t_stat;

endpackage

@@ src/triangle_lfo_tremolo.sv @@
// Top level of the triangle LFO tremolo: APB register file, controller and datapath.
// Depends on tlt_pkg, tlt_ctrl and tlt_dpath.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+---------------------------
//  input   | in        | i_in_valid / o_in_ready      | i_op, i_sample_in
//  output  | out       | o_out_valid / i_out_ready    | o_sample_out
//  config  | in        | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// A sweep tick or restart transaction is applied as it is accepted. An audio
// sample goes from acceptance through product, 31 restoring divide steps (one
// quotient bit per cycle), gain multiply and saturation into the output register.
// The next transaction is accepted while a result waits in the output register;
// a later sample stalls in its last step until that result is taken.
// Reset (synchronous, active low) clears FSM, phase, direction, depth; rate gets 1.
module triangle_lfo_tremolo #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_op,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [tlt_pkg::OUT_W-1:0]   o_sample_out,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [tlt_pkg::ADDR_W-1:0]         paddr,
    input  logic [tlt_pkg::DATA_W-1:0]         pwdata,
    output logic [tlt_pkg::DATA_W-1:0]         prdata,
    output logic                               pready
);
    import tlt_pkg::*;

    logic [REG_W-1:0]   r_rate_limit;
    logic [REG_W-1:0]   r_depth;
    logic               cfg_wr;
    logic               reg_idx;
    t_cmd               cmd;
    t_stat              stat;
    logic [PHASE_W-1:0] phase;

    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate_limit <= RATE_RESET;
            r_depth      <= DEPTH_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_RATE:  r_rate_limit <= pwdata[REG_W-1:0];
                REG_DEPTH: r_depth      <= pwdata[REG_W-1:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_RATE:  prdata = DATA_W'(r_rate_limit);
            REG_DEPTH: prdata = DATA_W'(r_depth);
            default:   prdata = '0;
        endcase
    end

    tlt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_op       (i_op),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    tlt_dpath #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_stat       (stat),
        .i_sample_in  (i_sample_in),
        .i_rate_limit (r_rate_limit),
        .i_depth      (r_depth),
        .o_phase      (phase),
        .i_out_ready  (i_out_ready),
        .o_out_valid  (o_out_valid),
        .o_sample_out (o_sample_out)
    );

    // A falling sweep always turns before the phase can sit at zero
    a_no_falling_at_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(stat.falling && phase == '0))
        else $error("falling direction with zero phase");

    // Ticks and restarts complete in the cycle they are accepted
    a_ctl_single_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_op != OP_SAMPLE) |=> o_in_ready)
        else $error("control transaction blocked the input");

    // A sample holds off new transactions while the divider runs
    a_sample_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_op == OP_SAMPLE) |=> !o_in_ready)
        else $error("input accepted during sample processing");

    // A result is only loaded into a free output register
    a_out_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_out |-> (!o_out_valid || i_out_ready))
        else $error("output result overwritten");

endmodule

@@ src/tlt_ctrl.sv @@
// Controller FSM of the tremolo: input handshake, op decode, divide sequencing.
// Depends on tlt_pkg; drives tlt_dpath through t_cmd and reads t_stat.
module tlt_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic [1:0]         i_op,
    output logic               o_in_ready,
    output tlt_pkg::t_cmd      o_cmd,
    input  tlt_pkg::t_stat     i_stat
);
    import tlt_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    // accept the unused op code; its only effect is latching the sample input
                    unique case (i_op)
                        OP_SAMPLE: begin
                            n_state = ST_PROD;
                        end
                        OP_TICK: begin
                            o_cmd.tick = 1'b1;
                        end
                        OP_RESTART: begin
                            o_cmd.restart = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PROD: begin
                o_cmd.load_prod = 1'b1;
                n_cnt           = '0;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_GAIN;
                end else begin
                    n_cnt = r_cnt + CNT_W'(1);
                end
            end
            ST_GAIN: begin
                o_cmd.load_gain = 1'b1;
                n_state         = ST_OUT;
            end
            ST_OUT: begin
                // hold until the previous result has left
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

@@ src/tlt_dpath.sv @@
// Datapath of the tremolo: triangle counter, restoring divider, gain multiply,
// saturation and output register. Depends on tlt_pkg; sequenced by tlt_ctrl.
module tlt_dpath #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  tlt_pkg::t_cmd                   i_cmd,
    output tlt_pkg::t_stat                  o_stat,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample_in,
    input  logic [tlt_pkg::REG_W-1:0]       i_rate_limit,
    input  logic [tlt_pkg::REG_W-1:0]       i_depth,
    output logic [tlt_pkg::PHASE_W-1:0]     o_phase,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic signed [tlt_pkg::OUT_W-1:0] o_sample_out
);
    import tlt_pkg::*;

    localparam int MUL_W = PROD_W + 1 + SAMPLE_BITS;

    logic [PHASE_W-1:0]            r_phase, n_phase;
    logic                          r_falling, n_falling;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic [PROD_W-1:0]             r_quo;
    logic [REG_W-1:0]              r_rem;
    logic signed [MUL_W-1:0]       r_mul;
    logic [OUT_W-1:0]              r_out;
    logic                          r_out_valid;

    logic [PHASE_W-1:0]            phase_inc, phase_dec;
    logic [REG_W:0]                rem_sh;
    logic [REG_W+1:0]              rem_diff;
    logic                          rem_ge;
    logic signed [MUL_W-1:0]       gain_ext, sample_ext;
    logic [MUL_W-OUT_W:0]          mul_hi;
    logic [OUT_W-1:0]              sat_val;

    // Triangle counter
    assign phase_inc = r_phase + PHASE_W'(1);
    assign phase_dec = r_phase - PHASE_W'(1);

    always_comb begin
        n_phase   = r_phase;
        n_falling = r_falling;
        if (i_cmd.restart) begin
            n_phase   = '0;
            n_falling = 1'b0;
        end else if (i_cmd.tick) begin
            if (!r_falling) begin
                n_phase = phase_inc;
                if (phase_inc > PHASE_W'(i_rate_limit)) begin
                    n_falling = 1'b1;
                end
            end else begin
                n_phase = phase_dec;
                if (phase_dec == '0) begin
                    n_falling = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= '0;
            r_falling <= 1'b0;
        end else begin
            r_phase   <= n_phase;
            r_falling <= n_falling;
        end
    end

    // Restoring divide: shift dividend bits into the remainder, MSB first
    assign rem_sh   = {r_rem, r_quo[PROD_W-1]};
    assign rem_diff = {1'b0, rem_sh} - (REG_W+2)'(i_rate_limit);
    assign rem_ge   = !rem_diff[REG_W+1];

    assign gain_ext   = MUL_W'($signed({1'b0, r_quo}));
    assign sample_ext = MUL_W'(r_sample);

    // Saturate to the signed output range
    assign mul_hi  = r_mul[MUL_W-1:OUT_W-1];
    assign sat_val = ((&mul_hi) || !(|mul_hi)) ? r_mul[OUT_W-1:0]
                   : (r_mul[MUL_W-1] ? SAT_MIN : SAT_MAX);

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_sample <= i_sample_in;
        end
        if (i_cmd.load_prod) begin
            r_quo <= PROD_W'(r_phase) * PROD_W'(i_depth);
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_quo <= {r_quo[PROD_W-2:0], rem_ge};
            r_rem <= rem_ge ? rem_diff[REG_W-1:0] : rem_sh[REG_W-1:0];
        end
        if (i_cmd.load_gain) begin
            // zero divisor gives zero gain
            r_mul <= (i_rate_limit == '0) ? '0 : gain_ext * sample_ext;
        end
        if (i_cmd.load_out) begin
            r_out <= sat_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_stat.falling  = r_falling;
    assign o_phase         = r_phase;
    assign o_out_valid     = r_out_valid;
    assign o_sample_out    = $signed(r_out);

endmodule
